// ----- src/tcst_pkg.sv -----
`default_nettype none
package tcst_pkg;

  localparam int unsigned DefMaxSlots = 16;

  // Input actions
  localparam logic [3:0] ACT_HELLO   = 4'd0;
  localparam logic [3:0] ACT_READY   = 4'd1;
  localparam logic [3:0] ACT_BYE     = 4'd2;
  localparam logic [3:0] ACT_PING    = 4'd3;
  localparam logic [3:0] ACT_PONG    = 4'd4;
  localparam logic [3:0] ACT_CPKT    = 4'd5;
  localparam logic [3:0] ACT_OTHER   = 4'd6;
  localparam logic [3:0] ACT_TUN     = 4'd7;
  localparam logic [3:0] ACT_TICK    = 4'd8;

  // Result kinds
  localparam logic [3:0] K_ACCEPTED  = 4'd0;
  localparam logic [3:0] K_BADPROTO  = 4'd1;
  localparam logic [3:0] K_BUSY      = 4'd2;
  localparam logic [3:0] K_WELCOME   = 4'd3;
  localparam logic [3:0] K_BADSESS   = 4'd4;
  localparam logic [3:0] K_PONG      = 4'd5;
  localparam logic [3:0] K_WRONGST   = 4'd6;
  localparam logic [3:0] K_TOTUN     = 4'd7;
  localparam logic [3:0] K_FORWARD   = 4'd8;
  localparam logic [3:0] K_UNREACH   = 4'd9;
  localparam logic [3:0] K_PING      = 4'd10;
  localparam logic [3:0] K_DISCONN   = 4'd11;
  localparam logic [3:0] K_ROLLBACK  = 4'd12;
  localparam logic [3:0] K_UNEXPECT  = 4'd13;
  localparam logic [3:0] K_TICKDONE  = 4'd14;

  // Slot states
  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_WELCOME = 2'd1;
  localparam logic [1:0] ST_READY   = 2'd2;
  localparam logic [1:0] ST_QUIET   = 2'd3;

  localparam logic [7:0] NO_SLOT = 8'd255;

  // Register indexes
  localparam logic [2:0] R_MAXCL = 3'd0;
  localparam logic [2:0] R_TMO   = 3'd1;
  localparam logic [2:0] R_VER   = 3'd2;
  localparam logic [2:0] R_POOL4 = 3'd3;
  localparam logic [2:0] R_POOL6 = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EXEC = 5'b00100,
    S_OUT  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  // One result transaction
  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  slot;
    logic [15:0] sess;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// ----- src/tcst_ram.sv -----
`default_nettype none
module tcst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                                       clk_i,
  input  wire                                       we_i,
  input  wire [$clog2((Depth > 1) ? Depth : 2)-1:0] waddr_i,
  input  wire [Width-1:0]                           wdata_i,
  input  wire [$clog2((Depth > 1) ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Single write port, registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- src/tunnel_client_session_table_top.sv -----
// Channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o  | action, slot_req, session_num, hello_ver,
//         |           |                        | now, dest_low, ip_family
// out     | output    | out_valid_o/out_stall_i| kind, slot, session_out, last
// cfg     | input     | APB psel/penable       | five registers at 4*i
//
// A tick visits each slot below the effective slot count in turn (read, decide,
// advance) and hands off any result for a slot before advancing; a hello scans
// one slot per cycle when its requested slot is taken, then claims the slot.
// Client messages and tunnel packets read the memories, then decide.
// The input is stalled from acceptance until the last result is taken.
// Reset frees every slot at once; a stalled result holds and the sequencer waits.
`default_nettype none
module tunnel_client_session_table_top
  import tcst_pkg::*;
#(
  parameter int unsigned MaxSlots = DefMaxSlots
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_stall_o,
  input  wire [3:0]    action_i,
  input  wire [7:0]    slot_req_i,
  input  wire [15:0]   session_num_i,
  input  wire [15:0]   hello_ver_i,
  input  wire [31:0]   now_i,
  input  wire [31:0]   dest_low_i,
  input  wire          ip_family_i,
  output logic         out_valid_o,
  input  wire          out_stall_i,
  output logic [3:0]   kind_o,
  output logic [7:0]   slot_o,
  output logic [15:0]  session_out_o,
  output logic         last_o,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire [4:0]    paddr,
  input  wire [31:0]   pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int unsigned IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned CntW = $clog2(MaxSlots + 1);

  // Configuration registers
  logic [4:0]  maxcl_q;
  logic [15:0] tmo_q, ver_q;
  logic [31:0] pool4_q, pool6_q;
  logic [2:0]  ridx;
  assign ridx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxcl_q <= 5'd16;
      tmo_q   <= 16'd60;
      ver_q   <= '0;
      pool4_q <= '0;
      pool6_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        R_MAXCL: maxcl_q <= pwdata[4:0];
        R_TMO:   tmo_q   <= pwdata[15:0];
        R_VER:   ver_q   <= pwdata[15:0];
        R_POOL4: pool4_q <= pwdata;
        R_POOL6: pool6_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      R_MAXCL: prdata = {27'd0, maxcl_q};
      R_TMO:   prdata = {16'd0, tmo_q};
      R_VER:   prdata = {16'd0, ver_q};
      R_POOL4: prdata = pool4_q;
      R_POOL6: prdata = pool6_q;
      default: prdata = '0;
    endcase
  end

  // Effective slot count
  logic [8:0] used;
  assign used = ({4'd0, maxcl_q} > 9'(MaxSlots)) ? 9'(MaxSlots) : {4'd0, maxcl_q};

  // Captured transaction
  logic [3:0]  act_q;
  logic [7:0]  cid_q;
  logic [15:0] sess_q;
  logic [31:0] now_q, dest_q;
  logic        fam_q;

  state_e st_q, st_d;
  logic [IdxW-1:0] idx_q, idx_d;         // slot under work
  logic [CntW-1:0] cnt_q, cnt_d;         // scan position
  logic            rd_wait_q, rd_wait_d; // RAM read in flight
  logic [1:0]      state_q [MaxSlots];
  res_t            res_q, res_d;
  logic            res_v_q, res_v_d;
  logic            done_q, done_d;       // no more work after result

  // Session and time memories
  logic [IdxW-1:0] ram_wa, ram_ra;
  logic [15:0]     sess_wd, sess_rd;
  logic [31:0]     time_wd, time_rd;
  logic            sess_we, time_we;

  tcst_ram #(.Width(16), .Depth(MaxSlots)) u_sess (
    .clk_i(clk_i), .we_i(sess_we), .waddr_i(ram_wa), .wdata_i(sess_wd),
    .raddr_i(ram_ra), .rdata_o(sess_rd));
  tcst_ram #(.Width(32), .Depth(MaxSlots)) u_time (
    .clk_i(clk_i), .we_i(time_we), .waddr_i(ram_wa), .wdata_i(time_wd),
    .raddr_i(ram_ra), .rdata_o(time_rd));

  assign in_stall_o  = (st_q != S_IDLE);
  assign out_valid_o = res_v_q;
  assign kind_o        = res_q.kind;
  assign slot_o        = res_q.slot;
  assign session_out_o = res_q.sess;
  assign last_o        = res_q.last;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = res_v_q && !out_stall_i;

  // Shared arithmetic: pool offset and tick ageing
  logic [31:0] off, diff;
  logic        off_ok;
  logic [1:0]  ost, ist;
  assign off    = dest_q - (fam_q ? pool6_q : pool4_q);
  assign diff   = now_q - time_rd;
  assign off_ok = off < {23'd0, used};
  assign ost    = state_q[off[IdxW-1:0]];
  assign ist    = state_q[idx_q];

  // A tunnel packet reads the session of its offset slot.
  assign ram_ra = (act_q == ACT_TUN) ? off[IdxW-1:0] : idx_q;
  assign ram_wa = idx_q;
  assign sess_wd = now_q[31:16] ^ now_q[15:0];
  assign time_wd = now_q;

  // Tunnel packet: reachable only through a live slot inside the pool
  logic tun_fail;
  assign tun_fail = !(off_ok && (ost == ST_READY || ost == ST_QUIET));

  // Sequencer combinational decisions
  logic        st_we;
  logic [1:0]  st_wd;
  logic        emit;
  res_t        emit_r;
  logic        emit_done;

  always_comb begin
    st_d      = st_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    rd_wait_d = 1'b0;
    res_v_d   = res_v_q;
    done_d    = done_q;
    res_d     = res_q;
    st_we     = 1'b0;
    st_wd     = ST_FREE;
    sess_we   = 1'b0;
    time_we   = 1'b0;
    emit      = 1'b0;
    emit_r    = '{kind: K_UNEXPECT, slot: NO_SLOT, sess: 16'd0, last: 1'b1};
    emit_done = 1'b1;
    unique case (st_q)
      S_IDLE: begin
        // Accept a transaction and pick its first step
        if (in_acc) begin
          cnt_d     = '0;
          idx_d     = '0;
          rd_wait_d = 1'b1;
          res_d     = '{kind: K_UNEXPECT, slot: NO_SLOT, sess: 16'd0, last: 1'b1};
          priority if (action_i == ACT_HELLO) begin
            if (hello_ver_i != ver_q) begin
              res_d.kind = K_BADPROTO; res_v_d = 1'b1; done_d = 1'b1; st_d = S_OUT;
            end else if ({1'b0, slot_req_i} < used &&
                         state_q[slot_req_i[IdxW-1:0]] == ST_FREE) begin
              idx_d = slot_req_i[IdxW-1:0]; st_d = S_EXEC;
            end else begin
              st_d = S_SCAN;
            end
          end else if (action_i >= ACT_READY && action_i <= ACT_CPKT) begin
            res_d.kind = K_BADSESS;
            idx_d = slot_req_i[IdxW-1:0];
            if ({1'b0, slot_req_i} < used) st_d = S_EXEC;
            else begin
              res_v_d = 1'b1; done_d = 1'b1; st_d = S_OUT;
            end
          end else if (action_i == ACT_TUN || action_i == ACT_TICK) begin
            st_d = S_EXEC;
          end else begin
            res_v_d = 1'b1; done_d = 1'b1; st_d = S_OUT;
          end
        end
      end
      S_SCAN: begin
        // Hello slot search, one slot per cycle
        if ({{(9-CntW){1'b0}}, cnt_q} >= used) begin
          emit = 1'b1;
          emit_r.kind = K_BUSY;
          st_d = S_OUT;
        end else if (state_q[cnt_q[IdxW-1:0]] == ST_FREE) begin
          idx_d = cnt_q[IdxW-1:0];
          st_d = S_EXEC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_EXEC: begin
        if (rd_wait_q && act_q != ACT_HELLO) begin
          // Memory read in flight
          st_d = S_EXEC;
        end else if (act_q == ACT_HELLO) begin
          sess_we = 1'b1; time_we = 1'b1; st_we = 1'b1; st_wd = ST_WELCOME;
          emit = 1'b1;
          emit_r = '{kind: K_WELCOME, slot: 8'(idx_q), sess: sess_wd, last: 1'b1};
          st_d = S_OUT;
        end else if (act_q == ACT_TUN) begin
          emit = 1'b1;
          if (tun_fail) emit_r = '{kind: K_UNREACH, slot: NO_SLOT, sess: 16'd0, last: 1'b1};
          else emit_r = '{kind: K_FORWARD, slot: off[7:0], sess: sess_rd, last: 1'b1};
          st_d = S_OUT;
        end else if (act_q == ACT_TICK) begin
          if ({{(9-CntW){1'b0}}, cnt_q} >= used) begin
            emit = 1'b1;
            emit_r.kind = K_TICKDONE;
            st_d = S_OUT;
          end else if (ist == ST_FREE) begin
            st_d = S_FIN;
          end else if (diff[31]) begin
            time_we = 1'b1; st_we = (ist == ST_QUIET); st_wd = ST_READY;
            emit = 1'b1; emit_done = 1'b0;
            emit_r = '{kind: K_ROLLBACK, slot: 8'(idx_q), sess: sess_rd, last: 1'b0};
            st_d = S_OUT;
          end else if (diff > {16'd0, tmo_q}) begin
            st_we = 1'b1; st_wd = ST_FREE;
            emit = 1'b1; emit_done = 1'b0;
            emit_r = '{kind: K_DISCONN, slot: 8'(idx_q), sess: sess_rd, last: 1'b0};
            st_d = S_OUT;
          end else if (diff > {17'd0, tmo_q[15:1]}) begin
            st_we = 1'b1; st_wd = ST_QUIET;
            emit = 1'b1; emit_done = 1'b0;
            emit_r = '{kind: K_PING, slot: 8'(idx_q), sess: sess_rd, last: 1'b0};
            st_d = S_OUT;
          end else begin
            st_d = S_FIN;
          end
        end else begin
          // Session-checked client messages
          if (ist == ST_FREE || sess_rd != sess_q) begin
            emit = 1'b1;
            emit_r = '{kind: K_BADSESS, slot: cid_q, sess: 16'd0, last: 1'b1};
          end else begin
            time_we = 1'b1;
            emit = 1'b1;
            emit_r.slot = cid_q;
            emit_r.sess = sess_rd;
            if (ist == ST_QUIET) begin
              st_we = 1'b1; st_wd = ST_READY;
            end
            unique case (act_q)
              ACT_READY: begin
                if (ist != ST_WELCOME) emit_r.kind = K_WRONGST;
                else begin
                  emit_r.kind = K_ACCEPTED; st_we = 1'b1; st_wd = ST_READY;
                end
              end
              ACT_BYE: begin
                emit_r.kind = K_ACCEPTED; st_we = 1'b1; st_wd = ST_FREE;
              end
              ACT_PING: emit_r.kind = K_PONG;
              ACT_PONG: emit_r.kind = K_ACCEPTED;
              default: emit_r.kind = (ist == ST_QUIET || ist == ST_READY) ?
                                     K_TOTUN : K_WRONGST;
            endcase
          end
          st_d = S_OUT;
        end
      end
      S_FIN: begin
        // Tick: advance to the next slot or finish
        if ({{(9-CntW){1'b0}}, cnt_q} + 9'd1 >= used) begin
          emit = 1'b1;
          emit_r.kind = K_TICKDONE;
          st_d = S_OUT;
        end else begin
          cnt_d = cnt_q + 1'b1;
          idx_d = IdxW'(cnt_q + 1'b1);
          rd_wait_d = 1'b1;
          st_d = S_EXEC;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          res_v_d = 1'b0;
          st_d = done_q ? S_IDLE : S_FIN;
        end
      end
      default: st_d = S_IDLE;
    endcase
    // Load a new result transaction
    if (emit) begin
      res_d   = emit_r;
      res_v_d = 1'b1;
      done_d  = emit_done;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      res_v_q   <= 1'b0;
      res_q     <= '0;
      rd_wait_q <= 1'b0;
      idx_q     <= '0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
      for (int k = 0; k < MaxSlots; k++) state_q[k] <= ST_FREE;
    end else begin
      st_q      <= st_d;
      res_v_q   <= res_v_d;
      res_q     <= res_d;
      rd_wait_q <= rd_wait_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
      if (st_we) state_q[idx_q] <= st_wd;
    end
  end

  // Transaction capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= action_i;
      cid_q  <= slot_req_i;
      sess_q <= session_num_i;
      now_q  <= now_i;
      dest_q <= dest_low_i;
      fam_q  <= ip_family_i;
    end
  end

  // Assertions
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_IDLE) |-> in_stall_o) else $error("accepted while busy");
  a_out_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (st_q == S_OUT)) else $error("result outside output state");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_o) |=> (st_q == S_IDLE)) else $error("work after last result");
endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Session table prediction and result checking.
class session_scoreboard;
  logic [4:0]  max_clients;
  logic [15:0] peer_timeout;
  logic [15:0] proto_version;
  logic [31:0] pool4;
  logic [31:0] pool6;
  logic [1:0]  slot_state [16];
  logic [15:0] slot_session [16];
  logic [31:0] slot_time [16];
  tcst_pkg::res_t pending_results [$];
  int errors;

  function new();
    max_clients = 16;
    peer_timeout = 60;
    proto_version = 0;
    pool4 = 0;
    pool6 = 0;
    errors = 0;
    for (int i = 0; i < 16; i++) begin
      slot_state[i] = tcst_pkg::ST_FREE;
      slot_session[i] = 0;
      slot_time[i] = 0;
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      tcst_pkg::R_MAXCL: max_clients = value[4:0];
      tcst_pkg::R_TMO: peer_timeout = value[15:0];
      tcst_pkg::R_VER: proto_version = value[15:0];
      tcst_pkg::R_POOL4: pool4 = value;
      tcst_pkg::R_POOL6: pool6 = value;
      default: ;
    endcase
  endfunction

  function int unsigned used_slots();
    return (max_clients > 16) ? 16 : max_clients;
  endfunction

  function void push_result(logic [3:0] kind, logic [7:0] slot, logic [15:0] sess);
    tcst_pkg::res_t r;
    r.kind = kind;
    r.slot = slot;
    r.sess = sess;
    r.last = 1'b0;
    pending_results.push_back(r);
  endfunction

  // Note an accepted input transaction and queue the results it causes.
  function void note_input(logic [3:0] action, logic [7:0] cid, logic [15:0] sess,
                           logic [15:0] ver, logic [31:0] now, logic [31:0] dest,
                           logic fam);
    int unsigned used;
    int unsigned id;
    logic [31:0] off;
    logic [31:0] diff;
    tcst_pkg::res_t r;
    used = used_slots();
    if (action == tcst_pkg::ACT_HELLO) begin
      if (ver != proto_version) begin
        push_result(tcst_pkg::K_BADPROTO, tcst_pkg::NO_SLOT, 16'd0);
      end else begin
        id = 255;
        if (cid < used && slot_state[cid] == tcst_pkg::ST_FREE) begin
          id = cid;
        end else begin
          for (int i = used - 1; i >= 0; i--)
            if (slot_state[i] == tcst_pkg::ST_FREE) id = i;
        end
        if (id == 255) begin
          push_result(tcst_pkg::K_BUSY, tcst_pkg::NO_SLOT, 16'd0);
        end else begin
          slot_time[id] = now;
          slot_session[id] = now[31:16] ^ now[15:0];
          slot_state[id] = tcst_pkg::ST_WELCOME;
          push_result(tcst_pkg::K_WELCOME, 8'(id), slot_session[id]);
        end
      end
    end else if (action >= tcst_pkg::ACT_READY && action <= tcst_pkg::ACT_CPKT) begin
      if (cid >= used) begin
        push_result(tcst_pkg::K_BADSESS, tcst_pkg::NO_SLOT, 16'd0);
      end else if (slot_state[cid] == tcst_pkg::ST_FREE || slot_session[cid] != sess) begin
        push_result(tcst_pkg::K_BADSESS, cid, 16'd0);
      end else begin
        slot_time[cid] = now;
        if (slot_state[cid] == tcst_pkg::ST_QUIET) slot_state[cid] = tcst_pkg::ST_READY;
        case (action)
          tcst_pkg::ACT_READY: begin
            if (slot_state[cid] != tcst_pkg::ST_WELCOME) begin
              push_result(tcst_pkg::K_WRONGST, cid, slot_session[cid]);
            end else begin
              slot_state[cid] = tcst_pkg::ST_READY;
              push_result(tcst_pkg::K_ACCEPTED, cid, slot_session[cid]);
            end
          end
          tcst_pkg::ACT_BYE: begin
            slot_state[cid] = tcst_pkg::ST_FREE;
            push_result(tcst_pkg::K_ACCEPTED, cid, slot_session[cid]);
          end
          tcst_pkg::ACT_PING: push_result(tcst_pkg::K_PONG, cid, slot_session[cid]);
          tcst_pkg::ACT_PONG: push_result(tcst_pkg::K_ACCEPTED, cid, slot_session[cid]);
          default: begin
            if (slot_state[cid] != tcst_pkg::ST_READY)
              push_result(tcst_pkg::K_WRONGST, cid, slot_session[cid]);
            else
              push_result(tcst_pkg::K_TOTUN, cid, slot_session[cid]);
          end
        endcase
      end
    end else if (action == tcst_pkg::ACT_TUN) begin
      off = dest - (fam ? pool6 : pool4);
      if (off < used && (slot_state[off] == tcst_pkg::ST_READY ||
                         slot_state[off] == tcst_pkg::ST_QUIET))
        push_result(tcst_pkg::K_FORWARD, off[7:0], slot_session[off]);
      else
        push_result(tcst_pkg::K_UNREACH, tcst_pkg::NO_SLOT, 16'd0);
    end else if (action == tcst_pkg::ACT_TICK) begin
      for (int i = 0; i < used; i++) begin
        if (slot_state[i] != tcst_pkg::ST_FREE) begin
          diff = now - slot_time[i];
          if (diff[31]) begin
            slot_time[i] = now;
            if (slot_state[i] == tcst_pkg::ST_QUIET) slot_state[i] = tcst_pkg::ST_READY;
            push_result(tcst_pkg::K_ROLLBACK, 8'(i), slot_session[i]);
          end else if (diff > peer_timeout) begin
            slot_state[i] = tcst_pkg::ST_FREE;
            push_result(tcst_pkg::K_DISCONN, 8'(i), slot_session[i]);
          end else if (diff > (peer_timeout >> 1)) begin
            slot_state[i] = tcst_pkg::ST_QUIET;
            push_result(tcst_pkg::K_PING, 8'(i), slot_session[i]);
          end
        end
      end
      push_result(tcst_pkg::K_TICKDONE, tcst_pkg::NO_SLOT, 16'd0);
    end else begin
      push_result(tcst_pkg::K_UNEXPECT, tcst_pkg::NO_SLOT, 16'd0);
    end
    r = pending_results.pop_back();
    r.last = 1'b1;
    pending_results.push_back(r);
  endfunction

  task report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Compare one accepted result transaction with the oldest expectation.
  task check_result(tcst_pkg::res_t got);
    tcst_pkg::res_t want;
    if (pending_results.size() == 0) begin
      report($sformatf("unexpected result kind=%0d slot=%0d", got.kind, got.slot));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind)
      report($sformatf("kind got %0d want %0d", got.kind, want.kind));
    if (got.slot !== want.slot)
      report($sformatf("slot got %0d want %0d", got.slot, want.slot));
    if (got.sess !== want.sess)
      report($sformatf("session got %h want %h", got.sess, want.sess));
    if (got.last !== want.last)
      report($sformatf("last got %0d want %0d", got.last, want.last));
  endtask
endclass

module testbench;
  import tcst_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] action_i = '0;
  logic [7:0] slot_req_i = '0;
  logic [15:0] session_num_i = '0;
  logic [15:0] hello_ver_i = '0;
  logic [31:0] now_i = '0;
  logic [31:0] dest_low_i = '0;
  logic ip_family_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] kind_o;
  logic [7:0] slot_o;
  logic [15:0] session_out_o;
  logic last_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  session_scoreboard table_model;
  logic [31:0] clock_now;
  bit stall_enable;

  tunnel_client_session_table_top DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("testbench: errors");
    $finish;
  end

  function automatic int unsigned gap_length();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Result side: random stall, check every accepted result transaction.
  initial begin
    res_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.kind = kind_o;
        got.slot = slot_o;
        got.sess = session_out_o;
        got.last = last_o;
        table_model.check_result(got);
      end
      @(negedge clk_i);
      out_stall_i <= stall_enable && ($urandom_range(0, 2) == 0);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    table_model.write_reg(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Wait until the table has answered everything (or the guard runs out), then idle.
  task automatic drain();
    int unsigned guard;
    guard = 0;
    while (table_model.pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (80) @(posedge clk_i);
  endtask

  task automatic send(logic [3:0] action, logic [7:0] cid, logic [15:0] sess,
                      logic [15:0] ver, logic [31:0] now, logic [31:0] dest, logic fam);
    int unsigned gap;
    gap = gap_length();
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i <= action;
    slot_req_i <= cid;
    session_num_i <= sess;
    hello_ver_i <= ver;
    now_i <= now;
    dest_low_i <= dest;
    ip_family_i <= fam;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    table_model.note_input(action, cid, sess, ver, now, dest, fam);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Pick a live slot so that client messages mostly pass the session check.
  task automatic send_client(logic [3:0] action);
    int unsigned id;
    logic [15:0] sess;
    id = $urandom_range(0, 16);
    sess = 16'($urandom);
    for (int k = 0; k < 4; k++) begin
      if (id < 16 && table_model.slot_state[id] != ST_FREE) break;
      id = $urandom_range(0, 15);
    end
    if (id < 16 && table_model.slot_state[id] != ST_FREE && $urandom_range(0, 7) != 0)
      sess = table_model.slot_session[id];
    send(action, (id == 16) ? 8'($urandom) : 8'(id), sess, 16'($urandom), clock_now,
         $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned id;
    logic fam;
    logic [31:0] base;
    pick = $urandom_range(0, 99);
    clock_now = clock_now + $urandom_range(0, 12);
    if ($urandom_range(0, 40) == 0) clock_now = clock_now - $urandom_range(1, 200);
    if (pick < 20) begin
      send(ACT_HELLO, ($urandom_range(0, 3) == 0) ? NO_SLOT : 8'($urandom_range(0, 20)),
           16'($urandom),
           ($urandom_range(0, 9) == 0) ? 16'($urandom) : table_model.proto_version,
           clock_now, $urandom, 1'($urandom_range(0, 1)));
    end else if (pick < 65) begin
      send_client(4'($urandom_range(ACT_READY, ACT_CPKT)));
    end else if (pick < 80) begin
      fam = 1'($urandom_range(0, 1));
      base = fam ? table_model.pool6 : table_model.pool4;
      id = $urandom_range(0, 18);
      send(ACT_TUN, 8'($urandom), 16'($urandom), 16'($urandom), clock_now,
           ($urandom_range(0, 5) == 0) ? 32'($urandom) : base + id, fam);
    end else if (pick < 95) begin
      send(ACT_TICK, 8'($urandom), 16'($urandom), 16'($urandom), clock_now, $urandom,
           1'($urandom_range(0, 1)));
    end else begin
      send(($urandom_range(0, 1) == 0) ? ACT_OTHER : 4'($urandom_range(9, 15)),
           8'($urandom), 16'($urandom), 16'($urandom), clock_now, $urandom,
           1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    table_model = new();
    clock_now = 32'h0001_0100;
    stall_enable = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings.
    send(ACT_HELLO, 8'd3, 0, 16'hFFFF, clock_now, 0, 0);
    send(ACT_HELLO, 8'd3, 0, 0, clock_now, 0, 0);
    send(ACT_HELLO, 8'd3, 0, 0, 32'hFFFF_0000, 0, 0);
    send(ACT_HELLO, NO_SLOT, 0, 0, 32'h8000_00FF, 0, 0);
    send(ACT_READY, 8'd3, table_model.slot_session[3], 0, clock_now, 0, 0);
    send(ACT_READY, 8'd3, table_model.slot_session[3], 0, clock_now, 0, 0);
    send(ACT_READY, 8'd3, 16'hFFFF, 0, clock_now, 0, 0);
    send(ACT_READY, 8'd200, 0, 0, clock_now, 0, 0);
    send(ACT_PING, 8'd3, table_model.slot_session[3], 0, clock_now, 0, 0);
    send(ACT_PONG, 8'd3, table_model.slot_session[3], 0, clock_now, 0, 0);
    send(ACT_CPKT, 8'd3, table_model.slot_session[3], 0, clock_now, 0, 0);
    send(ACT_CPKT, 8'd0, table_model.slot_session[0], 0, clock_now, 0, 0);
    send(ACT_OTHER, 8'd3, 0, 0, clock_now, 0, 0);
    send(4'd15, 8'd3, 0, 0, clock_now, 0, 0);
    send(ACT_TUN, 0, 0, 0, clock_now, 32'd3, 1'b0);
    send(ACT_TUN, 0, 0, 0, clock_now, 32'd3, 1'b1);
    send(ACT_TUN, 0, 0, 0, clock_now, 32'hFFFF_FFFF, 1'b0);
    send(ACT_TICK, 0, 0, 0, clock_now + 40, 0, 0);
    send(ACT_TICK, 0, 0, 0, clock_now - 5, 0, 0);
    send(ACT_TICK, 0, 0, 0, clock_now + 100, 0, 0);
    send(ACT_BYE, 8'd0, table_model.slot_session[0], 0, clock_now, 0, 0);
    drain();

    // Phases with different settings, the extremes among them.
    for (int phase = 0; phase < 5; phase++) begin
      stall_enable = (phase != 0);
      case (phase)
        0: begin
          write_reg(R_MAXCL, 32'd1);
          write_reg(R_TMO, 32'd1);
          write_reg(R_VER, 32'hFFFF);
          write_reg(R_POOL4, 32'hFFFF_FFFF);
          write_reg(R_POOL6, 32'h0);
        end
        1: begin
          write_reg(R_MAXCL, 32'd0);
          write_reg(R_TMO, 32'hFFFF);
        end
        2: begin
          write_reg(R_MAXCL, 32'd31);
          write_reg(R_TMO, 32'd20);
          write_reg(R_VER, $urandom);
          write_reg(R_POOL4, $urandom);
          write_reg(R_POOL6, 32'hFFFF_FFF8);
        end
        3: begin
          write_reg(R_MAXCL, $urandom_range(2, 15));
          write_reg(R_TMO, $urandom_range(2, 40));
          write_reg(R_POOL4, 32'hFFFF_FFFA);
          write_reg(R_POOL6, $urandom);
        end
        default: begin
          write_reg(R_MAXCL, 32'd16);
          write_reg(R_TMO, 32'd60);
          write_reg(R_VER, 32'd0);
        end
      endcase
      for (int n = 0; n < 20; n++) begin
        random_item();
        if (n == 10) begin
          while (table_model.pending_results.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    // Every expected result must have arrived.
    if (table_model.pending_results.size() != 0)
      table_model.report("results still outstanding at the end");

    if (table_model.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ----- filelist.f -----
src/tcst_pkg.sv
src/tcst_ram.sv
src/tunnel_client_session_table_top.sv
test/testbench.sv
